[hdl/dess_pkg.sv]
// ----------------------------------------------------------------------------
// dess_pkg
// Shared sizes, operation and status codes and the table write word of the
// double-ended sparse set.
// ----------------------------------------------------------------------------
package dess_pkg;

   // element count and derived widths
   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int BOUND_W  = IDX_W + 1;

   localparam logic [BOUND_W-1:0] CAP_BOUND = BOUND_W'(CAPACITY);

   // operation codes
   typedef enum logic [3:0] {
      MODE_ADD          = 4'd0,
      MODE_REMOVE_BACK  = 4'd1,
      MODE_REMOVE_FRONT = 4'd2,
      MODE_CONTAINS     = 4'd3,
      MODE_POP_BACK     = 4'd4,
      MODE_POP_FRONT    = 4'd5,
      MODE_CLEAR        = 4'd6,
      MODE_FILL         = 4'd7,
      MODE_RESTORE      = 4'd8,
      MODE_AT           = 4'd9,
      MODE_NEXT         = 4'd10,
      MODE_PREV         = 4'd11,
      MODE_BACK         = 4'd12,
      MODE_POSITION_OF  = 4'd13
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_STAMP = 2'd2,
      STATUS_BEYOND    = 2'd3
   } status_type;

   // one write into a table
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] data;
   } ram_wr_type;

endpackage

[hdl/double_ended_sparse_set.sv]
// ----------------------------------------------------------------------------
// double_ended_sparse_set
// Sparse set over 0..CAPACITY-1 kept as a dense list and its inverse
// position table, with members in list slots [start, end).
// ----------------------------------------------------------------------------
// An operation is taken on start while busy is low and its result shows for
// exactly one cycle on the rsp_ ports with rsp_valid, in the same cycle in
// which busy drops; the receiver cannot stall, and the next operation may be
// started in the cycle the result shows. Operations without list lookups
// beyond the first (contains, pops, clear, fill, restore, at, back,
// position_of) answer from the look state; next and prev go on to a fetch
// state, remove and add at the back to a swap state, add at the front to the
// other and swap states. Both tables read through a register (the position of
// the element must be known before the dependent list read) and have a single
// write port, so a swap writes in two halves. Both tables read as identity
// after reset by per-entry written marks, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_sparse_set
   import dess_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_mode,
   input  logic [7:0]         req_element,
   input  logic [7:0]         req_position,
   input  logic [8:0]         req_stamp_size,
   input  logic [8:0]         req_stamp_start,
   output logic               rsp_valid,
   output logic               rsp_member,
   output logic [7:0]         rsp_value,
   output logic [7:0]         rsp_slot,
   output logic [8:0]         rsp_size_now,
   output logic [8:0]         rsp_start_now,
   output logic [1:0]         rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_OTHER,
      ST_SWAP,
      ST_FETCH
   } state_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [IDX_W-1:0]   elem_ff, elem_in;
   logic [IDX_W-1:0]   posn_ff, posn_in;
   logic [BOUND_W-1:0] stamp_size_ff, stamp_size_in;
   logic [BOUND_W-1:0] stamp_start_ff, stamp_start_in;
   logic [BOUND_W-1:0] end_ff, end_in;
   logic [BOUND_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0]   dst_ff, dst_in;
   logic [IDX_W-1:0]   pe_ff, pe_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_member_ff, rsp_member_in;
   logic [IDX_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]   dense_raddr, dense_rdata;
   logic [IDX_W-1:0]   pos_raddr, pos_rdata;
   ram_wr_type         dense_wr, pos_wr;

   logic [BOUND_W-1:0] pe9, nxt9, end_m1, at_addr;
   logic               empty, in_old;

   // tables
   dess_ram u_dense (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (dense_raddr),
      .rd_data (dense_rdata),
      .wr      (dense_wr)
   );

   dess_ram u_pos (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata),
      .wr      (pos_wr)
   );

   // helpers on the current bounds
   assign pe9     = {1'b0, pos_rdata};
   assign nxt9    = pe9 + BOUND_W'(1);
   assign end_m1  = end_ff - BOUND_W'(1);
   assign at_addr = start_ff + {1'b0, req_position};
   assign empty   = (end_ff == start_ff);
   assign in_old  = (pe9 >= start_ff) && (pe9 < end_ff);

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      elem_in        = elem_ff;
      posn_in        = posn_ff;
      stamp_size_in  = stamp_size_ff;
      stamp_start_in = stamp_start_ff;
      end_in         = end_ff;
      start_in       = start_ff;
      dst_in         = dst_ff;
      pe_in          = pe_ff;
      rsp_valid_in   = 1'b0;
      rsp_member_in  = rsp_member_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_status_in  = rsp_status_ff;
      dense_raddr    = elem_ff;
      pos_raddr      = elem_ff;
      dense_wr       = '0;
      pos_wr         = '0;

      case (state_ff)
         ST_IDLE: begin
            pos_raddr = req_element;
            // list slot the operation will most likely need
            case (mode_type'(req_mode))
               MODE_ADD:          dense_raddr = end_ff[IDX_W-1:0];
               MODE_REMOVE_BACK,
               MODE_BACK:         dense_raddr = end_m1[IDX_W-1:0];
               MODE_REMOVE_FRONT: dense_raddr = start_ff[IDX_W-1:0];
               MODE_AT:           dense_raddr = at_addr[IDX_W-1:0];
               default:           dense_raddr = end_ff[IDX_W-1:0];
            endcase
            if (start) begin
               state_in       = ST_LOOK;
               mode_in        = mode_type'(req_mode);
               elem_in        = req_element;
               posn_in        = req_position;
               stamp_size_in  = req_stamp_size;
               stamp_start_in = req_stamp_start;
            end
         end

         ST_LOOK: begin
            pe_in         = pos_rdata;
            rsp_value_in  = '0;
            rsp_slot_in   = '0;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            case (mode_ff)
               MODE_ADD: begin
                  if (pe9 >= end_ff) begin
                     // swap in at the back, first half of the exchange
                     dst_in       = end_ff[IDX_W-1:0];
                     end_in       = end_ff + BOUND_W'(1);
                     dense_wr     = '{en: 1'b1, addr: pos_rdata, data: dense_rdata};
                     pos_wr       = '{en: 1'b1, addr: dense_rdata, data: pos_rdata};
                     state_in     = ST_SWAP;
                     rsp_valid_in = 1'b0;
                  end else if (pe9 < start_ff) begin
                     // swap in at the front, fetch the slot before it
                     start_in     = start_ff - BOUND_W'(1);
                     dst_in       = start_in[IDX_W-1:0];
                     dense_raddr  = start_in[IDX_W-1:0];
                     state_in     = ST_OTHER;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_REMOVE_BACK: begin
                  if (in_old) begin
                     end_in       = end_m1;
                     dst_in       = end_m1[IDX_W-1:0];
                     dense_wr     = '{en: 1'b1, addr: pos_rdata, data: dense_rdata};
                     pos_wr       = '{en: 1'b1, addr: dense_rdata, data: pos_rdata};
                     state_in     = ST_SWAP;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_REMOVE_FRONT: begin
                  if (in_old) begin
                     start_in     = start_ff + BOUND_W'(1);
                     dst_in       = start_ff[IDX_W-1:0];
                     dense_wr     = '{en: 1'b1, addr: pos_rdata, data: dense_rdata};
                     pos_wr       = '{en: 1'b1, addr: dense_rdata, data: pos_rdata};
                     state_in     = ST_SWAP;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_POP_BACK: begin
                  if (empty) rsp_status_in = STATUS_EMPTY;
                  else end_in = end_m1;
               end
               MODE_POP_FRONT: begin
                  if (empty) rsp_status_in = STATUS_EMPTY;
                  else start_in = start_ff + BOUND_W'(1);
               end
               MODE_CLEAR: begin
                  end_in   = '0;
                  start_in = '0;
               end
               MODE_FILL: begin
                  end_in   = CAP_BOUND;
                  start_in = '0;
               end
               MODE_RESTORE: begin
                  if ((stamp_start_ff <= stamp_size_ff) && (stamp_size_ff <= CAP_BOUND)) begin
                     end_in   = stamp_size_ff;
                     start_in = stamp_start_ff;
                  end else begin
                     rsp_status_in = STATUS_BAD_STAMP;
                  end
               end
               MODE_AT: begin
                  if ({1'b0, posn_ff} < (end_ff - start_ff)) rsp_value_in = dense_rdata;
                  else rsp_status_in = STATUS_BEYOND;
               end
               MODE_NEXT: begin
                  rsp_value_in = elem_ff;
                  if (nxt9 < end_ff) begin
                     dense_raddr  = nxt9[IDX_W-1:0];
                     state_in     = ST_FETCH;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_PREV: begin
                  rsp_value_in = elem_ff;
                  if (pe9 > start_ff) begin
                     dense_raddr  = pos_rdata - IDX_W'(1);
                     state_in     = ST_FETCH;
                     rsp_valid_in = 1'b0;
                  end
               end
               MODE_BACK: begin
                  if (empty) rsp_status_in = STATUS_EMPTY;
                  else rsp_value_in = dense_rdata;
               end
               MODE_POSITION_OF: begin
                  rsp_slot_in = pos_rdata;
               end
               default: begin
               end
            endcase
            // membership after the operation
            rsp_member_in = (pe9 >= start_in) && (pe9 < end_in);
            if (mode_ff == MODE_ADD) rsp_member_in = 1'b1;
            if ((mode_ff == MODE_REMOVE_BACK) || (mode_ff == MODE_REMOVE_FRONT)) begin
               rsp_member_in = 1'b0;
            end
         end

         ST_OTHER: begin
            // first half of a front swap with the fetched neighbor
            dense_wr = '{en: 1'b1, addr: pe_ff, data: dense_rdata};
            pos_wr   = '{en: 1'b1, addr: dense_rdata, data: pe_ff};
            state_in = ST_SWAP;
         end

         ST_SWAP: begin
            // second half, element lands on its destination slot
            dense_wr     = '{en: 1'b1, addr: dst_ff, data: elem_ff};
            pos_wr       = '{en: 1'b1, addr: elem_ff, data: dst_ff};
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end

         ST_FETCH: begin
            rsp_value_in = dense_rdata;
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         end_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         end_ff       <= end_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      elem_ff        <= elem_in;
      posn_ff        <= posn_in;
      stamp_size_ff  <= stamp_size_in;
      stamp_start_ff <= stamp_start_in;
      dst_ff         <= dst_in;
      pe_ff          <= pe_in;
      rsp_member_ff  <= rsp_member_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // ports
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_member    = rsp_member_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_size_now  = end_ff;
   assign rsp_start_now = start_ff;
   assign rsp_status    = rsp_status_ff;

   // checks
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (start_ff <= end_ff) && (end_ff <= CAP_BOUND))
      else $error("set bounds out of order");

   a_result_on_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("operation finished without a result word");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word repeated");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(dense_wr.en || pos_wr.en))
      else $error("table written while idle");

endmodule

[hdl/dess_ram.sv]
// ----------------------------------------------------------------------------
// dess_ram
// Permutation table with one write port and one registered read port.
// Every entry reads as its own index until it is first written.
// ----------------------------------------------------------------------------
module dess_ram
   import dess_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] rd_data,
   input  ram_wr_type       wr
);

   logic [IDX_W-1:0]    mem_ff [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    rd_addr_ff;

   // written marks, identity until the first write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_addr];
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   // storage and read register
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : rd_addr_ff;

endmodule
